### rtl/core/packet_deframer_crc16_check_core_macros.svh
// assertion macros shared by the deframer rtl
`ifndef PACKET_DEFRAMER_CRC16_CHECK_CORE_MACROS_SVH
`define PACKET_DEFRAMER_CRC16_CHECK_CORE_MACROS_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define PDC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("deframer assertion failed");

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define PDC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("deframer assertion failed");

`endif

### rtl/core/pdc_pkg.sv
// types, codes and crc helper for the packet deframer
`default_nettype none

package pdc_pkg;

  localparam int unsigned HDR_LEN    = 8;
  localparam int unsigned RES_DEPTH  = 2;
  localparam int unsigned RES_PTR_W  = $clog2(RES_DEPTH);
  localparam int unsigned RES_CNT_W  = $clog2(RES_DEPTH + 1);

  localparam logic [7:0]  MAGIC_FIRST_RST  = 8'd77;
  localparam logic [7:0]  MAGIC_SECOND_RST = 8'd76;
  localparam logic [15:0] CRC_INIT         = 16'hFFFF;

  // register word index, taken from paddr[2]
  localparam logic REG_MAGIC_FIRST  = 1'b0;
  localparam logic REG_MAGIC_SECOND = 1'b1;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TRUNC_HDR = 3'd1,
    ST_TRUNC_PAY = 3'd2,
    ST_BAD_MAGIC = 3'd3,
    ST_CRC_ERR   = 3'd4
  } status_e;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_REPORT  = 1'b1
  } kind_e;

  typedef enum logic [3:0] {
    MODE_COLLECT = 4'b0001,
    MODE_PAYLOAD = 4'b0010,
    MODE_HUNT    = 4'b0100,
    MODE_DONE    = 4'b1000
  } mode_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  pbyte;
    status_e     status;
    logic [7:0]  ver;
    logic [7:0]  mtype;
    logic [15:0] len;
    logic [15:0] crcr;
    logic [15:0] crcc;
    logic [15:0] bad;
    logic [31:0] ofs;
  } res_t;

  // all results caused by one byte
  typedef struct packed {
    logic two;
    res_t r0;
    res_t r1;
  } pdc_entry_t;

  // crc-16-ccitt, poly 0x1021, one byte in table-free form
  function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
    logic [7:0] x;
    x = crc[15:8] ^ b;
    x = x ^ {4'h0, x[7:4]};
    return {crc[7:0], 8'h00} ^ {x[3:0], 12'h000} ^ {3'b000, x, 5'b00000} ^ {8'h00, x};
  endfunction

  // held header layout: version, type, length, crc
  function automatic res_t make_report(status_e st, logic [47:0] hdr,
                                       logic [15:0] crcc, logic [31:0] ofs);
    res_t r;
    r        = '0;
    r.kind   = KIND_REPORT;
    r.status = st;
    r.ver    = hdr[47:40];
    r.mtype  = hdr[39:32];
    r.len    = hdr[31:16];
    r.crcr   = hdr[15:0];
    r.crcc   = crcc;
    r.ofs    = ofs;
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/core/pdc_parser.sv
// header window, magic search, crc and frame state for one byte a cycle while fire_i is high
`default_nettype none

`include "packet_deframer_crc16_check_core_macros.svh"

module pdc_parser import pdc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  logic [7:0] byte_i,
  input  logic       eos_i,
  input  logic [7:0] magic_first_i,
  input  logic [7:0] magic_second_i,
  output logic       push_o,
  output pdc_entry_t entry_o
);

  mode_e       mode_q, mode_d, mode_cur;
  logic [2:0]  fill_q, fill_d;
  logic [7:0]  win_q [HDR_LEN];
  logic [7:0]  win_d [HDR_LEN];
  logic [7:0]  wfull [HDR_LEN];
  logic [7:0]  win_sh [HDR_LEN];
  logic [15:0] crc_q, crc_d, crc_n, crc_h;
  logic [15:0] rem_q, rem_d, rem_n;
  logic [47:0] hdr_q, hdr_d, hdr_n;
  logic [31:0] pos_q, pos_d;
  logic [31:0] fs_q, fs_d, fs_base, fs_cur;
  logic [3:0]  fill_n, fill_cur;
  logic [3:0]  src;
  logic [2:0]  sh, hit;
  logic        found, magic_front;
  logic        have_a, have_b;
  res_t        r_a, r_b;

  // window as it stands once this byte is written in
  always_comb begin
    for (int i = 0; i < HDR_LEN; i++) begin
      wfull[i] = (fill_q == 3'(i)) ? byte_i : win_q[i];
    end
  end

  assign fill_n      = {1'b0, fill_q} + 4'd1;
  assign fs_base     = (fill_q == 3'd0) ? pos_q : fs_q;
  assign magic_front = (wfull[0] == magic_first_i) && (wfull[1] == magic_second_i);

  // first magic pair behind a rejected header start
  always_comb begin
    found = 1'b0;
    hit   = 3'd7;
    for (int j = HDR_LEN - 2; j >= 1; j--) begin
      if ((wfull[j] == magic_first_i) && (wfull[j + 1] == magic_second_i)) begin
        found = 1'b1;
        hit   = 3'(j);
      end
    end
  end

  always_comb begin
    sh = 3'd0;
    if ((mode_q == MODE_HUNT) && (fill_n >= 4'd2) && !magic_front) begin
      sh = 3'd1;
    end else if ((mode_q == MODE_COLLECT) && (fill_n == 4'(HDR_LEN)) && !magic_front) begin
      // no pair found: keep only the last byte
      sh = found ? hit : 3'd7;
    end
  end

  always_comb begin
    for (int i = 0; i < HDR_LEN; i++) begin
      src       = 4'(i) + {1'b0, sh};
      win_sh[i] = src[3] ? 8'h00 : wfull[src[2:0]];
    end
  end

  assign crc_n = crc_byte(crc_q, byte_i);
  assign rem_n = rem_q - 16'd1;
  assign hdr_n = {wfull[2], wfull[3], wfull[4], wfull[5], wfull[6], wfull[7]};
  assign crc_h = crc_byte(crc_byte(crc_byte(crc_byte(CRC_INIT, wfull[2]), wfull[3]),
                                   wfull[4]), wfull[5]);

  always_comb begin
    mode_d   = mode_q;
    fill_d   = fill_q;
    win_d    = win_q;
    crc_d    = crc_q;
    rem_d    = rem_q;
    hdr_d    = hdr_q;
    pos_d    = pos_q;
    fs_d     = fs_q;
    mode_cur = mode_q;
    fs_cur   = fs_base + {29'd0, sh};
    fill_cur = fill_n - {1'b0, sh};
    have_a   = 1'b0;
    have_b   = 1'b0;
    r_a      = '0;
    r_b      = '0;

    if (fire_i && (mode_q != MODE_DONE)) begin
      pos_d = pos_q + 32'd1;
      unique case (mode_q)
        MODE_PAYLOAD: begin
          have_a  = 1'b1;
          r_a.kind  = KIND_PAYLOAD;
          r_a.pbyte = byte_i;
          crc_d   = crc_n;
          rem_d   = rem_n;
          if (rem_n == 16'd0) begin
            have_b = 1'b1;
            r_b    = make_report((hdr_q[15:0] == crc_n) ? ST_OK : ST_CRC_ERR,
                                 hdr_q, crc_n, fs_q);
            mode_d = MODE_COLLECT;
            fill_d = 3'd0;
          end else if (eos_i) begin
            have_b = 1'b1;
            r_b    = make_report(ST_TRUNC_PAY, hdr_q, 16'h0000, fs_q);
          end
          if (eos_i) begin
            mode_d = MODE_DONE;
          end
        end
        MODE_COLLECT, MODE_HUNT: begin
          win_d = win_sh;
          if (mode_q == MODE_HUNT) begin
            if ((fill_n >= 4'd2) && magic_front) begin
              mode_cur = MODE_COLLECT;
            end
          end else if (fill_n == 4'(HDR_LEN)) begin
            if (!magic_front) begin
              have_a     = 1'b1;
              r_a.kind   = KIND_REPORT;
              r_a.status = ST_BAD_MAGIC;
              r_a.bad    = {wfull[0], wfull[1]};
              r_a.ofs    = fs_base;
              mode_cur   = found ? MODE_COLLECT : MODE_HUNT;
            end else begin
              hdr_d    = hdr_n;
              crc_d    = crc_h;
              rem_d    = hdr_n[31:16];
              fill_cur = 4'd0;
              if (hdr_n[31:16] == 16'd0) begin
                have_a   = 1'b1;
                r_a      = make_report((hdr_n[15:0] == crc_h) ? ST_OK : ST_CRC_ERR,
                                       hdr_n, crc_h, fs_cur);
                mode_cur = MODE_COLLECT;
              end else begin
                mode_cur = MODE_PAYLOAD;
              end
            end
          end
          if (eos_i) begin
            if (mode_cur == MODE_PAYLOAD) begin
              have_b = 1'b1;
              r_b    = make_report(ST_TRUNC_PAY, hdr_n, 16'h0000, fs_cur);
            end else if ((mode_cur == MODE_COLLECT) && (fill_cur != 4'd0)) begin
              have_b     = 1'b1;
              r_b.kind   = KIND_REPORT;
              r_b.status = ST_TRUNC_HDR;
              r_b.ofs    = fs_cur;
            end
            mode_d = MODE_DONE;
          end else begin
            mode_d = mode_cur;
          end
          fill_d = fill_cur[2:0];
          fs_d   = fs_cur;
        end
        default: begin
          mode_d = mode_q;
        end
      endcase
    end
  end

  assign push_o      = have_a || have_b;
  assign entry_o.two = have_a && have_b;
  assign entry_o.r0  = have_a ? r_a : r_b;
  assign entry_o.r1  = r_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_COLLECT;
      fill_q <= 3'd0;
      pos_q  <= 32'd0;
      fs_q   <= 32'd0;
    end else begin
      mode_q <= mode_d;
      fill_q <= fill_d;
      pos_q  <= pos_d;
      fs_q   <= fs_d;
    end
  end

  // slots at or past the fill count are never read before being written
  always_ff @(posedge clk_i) begin
    win_q <= win_d;
    crc_q <= crc_d;
    rem_q <= rem_d;
    hdr_q <= hdr_d;
  end

  `PDC_ASSERT_IMPL(a_hunt_one_byte, mode_q == MODE_HUNT, fill_q == 3'd1)
  `PDC_ASSERT_NEXT(a_done_sticky, mode_q == MODE_DONE, mode_q == MODE_DONE)

endmodule

`default_nettype wire

### rtl/core/pdc_res_fifo.sv
// result queue: one entry per byte that gives results, drained one word a cycle while out_ready_i is high
`default_nettype none

`include "packet_deframer_crc16_check_core_macros.svh"

module pdc_res_fifo import pdc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  pdc_entry_t entry_i,
  output logic       full_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output res_t       res_o,
  output logic       last_o
);

  localparam logic [RES_CNT_W-1:0] CNT_FULL = RES_CNT_W'(RES_DEPTH);

  pdc_entry_t           mem_q [RES_DEPTH];
  pdc_entry_t           head;
  logic [RES_PTR_W-1:0] wr_q, rd_q;
  logic [RES_CNT_W-1:0] count_q, count_d;
  logic                 sub_q;
  logic                 pop_word, pop_entry;

  assign head        = mem_q[rd_q];
  assign out_valid_o = (count_q != '0);
  assign full_o      = (count_q == CNT_FULL);
  assign res_o       = sub_q ? head.r1 : head.r0;
  assign last_o      = sub_q || !head.two;
  assign pop_word    = out_valid_o && out_ready_i;
  assign pop_entry   = pop_word && last_o;

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_entry) begin
      count_d = count_q + RES_CNT_W'(1);
    end else if (!push_i && pop_entry) begin
      count_d = count_q - RES_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
      sub_q   <= 1'b0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_q <= wr_q + RES_PTR_W'(1);
      end
      if (pop_entry) begin
        rd_q  <= rd_q + RES_PTR_W'(1);
        sub_q <= 1'b0;
      end else if (pop_word) begin
        sub_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  `PDC_ASSERT_IMPL(a_no_push_when_full, push_i, count_q != CNT_FULL)
  `PDC_ASSERT_IMPL(a_second_word_valid, sub_q, (count_q != '0) && head.two)

endmodule

`default_nettype wire

### rtl/core/packet_deframer_crc16_check_core.sv
// top level of the magic-synchronised packet deframer with crc-16 check
//
//  channel  direction  handshake               words
//  in       input      in_valid_i/in_ready_o   data_byte_i, end_of_stream_i
//  out      output     out_valid_o/out_ready_i result_kind_o .. last_result_o
//  cfg      input      psel/penable/pwrite     magic_first, magic_second
//
// one byte is taken every cycle while the result queue is not full; a byte that gives two results
// takes two output words, the limit being the single output word per cycle of the queue
// a byte waits in the input register, and its results then pass through the result queue
// async active-low reset, no clearing pass; the magic registers return to 'M' 'L'
// output stalls back up through the two-entry result queue to in_ready_o
`default_nettype none

module packet_deframer_crc16_check_core import pdc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_stream_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        result_kind_o,
  output logic [7:0]  payload_byte_o,
  output logic [2:0]  status_o,
  output logic [7:0]  version_o,
  output logic [7:0]  message_type_o,
  output logic [15:0] payload_length_o,
  output logic [15:0] crc_received_o,
  output logic [15:0] crc_calc_o,
  output logic [15:0] bad_magic_o,
  output logic [31:0] frame_offset_o,
  output logic        last_result_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic       stg_v_q, stg_v_d;
  logic [7:0] stg_byte_q;
  logic       stg_eos_q;
  logic       in_acc, fire, full;
  logic [7:0] mf_q, ms_q;
  logic       cfg_wr;
  logic       push;
  pdc_entry_t entry;
  res_t       res;

  // input register
  assign in_acc     = in_valid_i && in_ready_o;
  assign fire       = stg_v_q && !full;
  assign in_ready_o = !stg_v_q || fire;

  always_comb begin
    stg_v_d = stg_v_q;
    if (in_acc) begin
      stg_v_d = 1'b1;
    end else if (fire) begin
      stg_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_v_q <= 1'b0;
    end else begin
      stg_v_q <= stg_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      stg_byte_q <= data_byte_i;
      stg_eos_q  <= end_of_stream_i;
    end
  end

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mf_q <= MAGIC_FIRST_RST;
      ms_q <= MAGIC_SECOND_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_MAGIC_SECOND) begin
        ms_q <= pwdata[7:0];
      end else begin
        mf_q <= pwdata[7:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_MAGIC_SECOND) begin
      prdata = {24'h000000, ms_q};
    end else begin
      prdata = {24'h000000, mf_q};
    end
  end

  pdc_parser u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fire_i         (fire),
    .byte_i         (stg_byte_q),
    .eos_i          (stg_eos_q),
    .magic_first_i  (mf_q),
    .magic_second_i (ms_q),
    .push_o         (push),
    .entry_o        (entry)
  );

  pdc_res_fifo u_res_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .entry_i     (entry),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res),
    .last_o      (last_result_o)
  );

  assign result_kind_o    = res.kind;
  assign payload_byte_o   = res.pbyte;
  assign status_o         = res.status;
  assign version_o        = res.ver;
  assign message_type_o   = res.mtype;
  assign payload_length_o = res.len;
  assign crc_received_o   = res.crcr;
  assign crc_calc_o       = res.crcc;
  assign bad_magic_o      = res.bad;
  assign frame_offset_o   = res.ofs;

endmodule

`default_nettype wire

### tb/tb_packet_deframer_crc16_check_core.sv
// self-checking testbench for the magic-synchronised packet deframer with crc-16 check
module tb_packet_deframer_crc16_check_core;
  timeunit 1ns;
  timeprecision 1ps;

  import pdc_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  // tracks the deframer state and holds the words each accepted byte must produce
  class stream_tracker;
    typedef struct {
      res_t word;
      logic last;
    } due_t;

    logic [7:0]  magic_a;
    logic [7:0]  magic_b;
    logic [7:0]  win [8];
    logic [3:0]  fill;
    mode_e       mode;
    logic [15:0] crc_acc;
    logic [15:0] left;
    logic [47:0] hdr;
    logic [31:0] pos;
    logic [31:0] start;
    res_t        outbox [2];
    int          out_n;
    due_t        due [$];
    int          faults;

    function new();
      magic_a = MAGIC_FIRST_RST;
      magic_b = MAGIC_SECOND_RST;
      foreach (win[i]) win[i] = 8'h00;
      fill    = 4'd0;
      mode    = MODE_COLLECT;
      crc_acc = 16'hFFFF;
      left    = 16'd0;
      hdr     = 48'd0;
      pos     = 32'd0;
      start   = 32'd0;
      out_n   = 0;
      faults  = 0;
    endfunction

    // crc-16-ccitt, msb first, one byte
    static function logic [15:0] crc_next(logic [15:0] c, logic [7:0] b);
      int k;
      c = c ^ {b, 8'h00};
      for (k = 0; k < 8; k++) begin
        c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
      end
      return c;
    endfunction

    function void set_magic(logic idx, logic [7:0] v);
      if (idx == REG_MAGIC_FIRST) magic_a = v;
      else magic_b = v;
    endfunction

    function int pending_count();
      return due.size();
    endfunction

    function void emit(res_t r);
      outbox[out_n] = r;
      out_n++;
    endfunction

    function res_t frame_word(status_e st, logic [15:0] crc);
      res_t r;
      r        = '0;
      r.kind   = KIND_REPORT;
      r.status = st;
      r.ver    = hdr[47:40];
      r.mtype  = hdr[39:32];
      r.len    = hdr[31:16];
      r.crcr   = hdr[15:0];
      r.crcc   = crc;
      r.ofs    = start;
      return r;
    endfunction

    function bit magic_front();
      return fill >= 4'd2 && win[0] == magic_a && win[1] == magic_b;
    endfunction

    function void shift_out();
      int i;
      for (i = 0; i < 7; i++) win[i] = win[i+1];
      win[7] = 8'h00;
      if (fill > 4'd0) fill--;
      start++;
    endfunction

    function void realign();
      while (fill >= 4'd2 && !magic_front()) shift_out();
      mode = magic_front() ? MODE_COLLECT : MODE_HUNT;
    endfunction

    function void take_header();
      res_t r;
      int   i;
      if (win[0] != magic_a || win[1] != magic_b) begin
        r        = '0;
        r.kind   = KIND_REPORT;
        r.status = ST_BAD_MAGIC;
        r.bad    = {win[0], win[1]};
        r.ofs    = start;
        emit(r);
        shift_out();
        realign();
        return;
      end
      hdr     = {win[2], win[3], win[4], win[5], win[6], win[7]};
      crc_acc = 16'hFFFF;
      for (i = 2; i < 6; i++) crc_acc = crc_next(crc_acc, win[i]);
      left = hdr[31:16];
      foreach (win[j]) win[j] = 8'h00;
      fill = 4'd0;
      if (left == 16'd0) begin
        emit(frame_word((hdr[15:0] == crc_acc) ? ST_OK : ST_CRC_ERR, crc_acc));
        mode = MODE_COLLECT;
      end else begin
        mode = MODE_PAYLOAD;
      end
    endfunction

    function void note_byte(logic [7:0] b, logic eos);
      res_t       r;
      logic [31:0] at;
      int         i;
      out_n = 0;
      if (mode == MODE_DONE) return;
      at = pos;
      pos++;
      if (mode == MODE_PAYLOAD) begin
        r       = '0;
        r.kind  = KIND_PAYLOAD;
        r.pbyte = b;
        emit(r);
        crc_acc = crc_next(crc_acc, b);
        left--;
        if (left == 16'd0) begin
          emit(frame_word((hdr[15:0] == crc_acc) ? ST_OK : ST_CRC_ERR, crc_acc));
          mode = MODE_COLLECT;
          fill = 4'd0;
        end else if (eos) begin
          emit(frame_word(ST_TRUNC_PAY, 16'd0));
        end
        if (eos) mode = MODE_DONE;
      end else begin
        if (fill == 4'd0) start = at;
        if (fill >= 4'd8) fill = 4'd7;
        win[fill[2:0]] = b;
        fill++;
        if (mode == MODE_HUNT) realign();
        else if (fill == 4'd8) take_header();
        if (eos) begin
          if (mode == MODE_PAYLOAD) begin
            emit(frame_word(ST_TRUNC_PAY, 16'd0));
          end else if (mode == MODE_COLLECT && fill > 4'd0) begin
            r        = '0;
            r.kind   = KIND_REPORT;
            r.status = ST_TRUNC_HDR;
            r.ofs    = start;
            emit(r);
          end
          mode = MODE_DONE;
        end
      end
      for (i = 0; i < out_n; i++) due.push_back('{word: outbox[i], last: (i == out_n - 1)});
    endfunction

    function void cmp(string what, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t mismatch %s: expected %h actual %h", $time, what, want, got);
        faults++;
      end
    endfunction

    function void check_word(res_t got, logic got_last);
      due_t want;
      if (due.size() == 0) begin
        $display("%0t unexpected word: expected none, actual kind %0d status %0d",
                 $time, got.kind, got.status);
        faults++;
        return;
      end
      want = due.pop_front();
      cmp("result_kind", want.word.kind, got.kind);
      cmp("payload_byte", want.word.pbyte, got.pbyte);
      cmp("status", want.word.status, got.status);
      cmp("version", want.word.ver, got.ver);
      cmp("message_type", want.word.mtype, got.mtype);
      cmp("payload_length", want.word.len, got.len);
      cmp("crc_received", want.word.crcr, got.crcr);
      cmp("crc_calc", want.word.crcc, got.crcc);
      cmp("bad_magic", want.word.bad, got.bad);
      cmp("frame_offset", want.word.ofs, got.ofs);
      cmp("last_result", want.last, got_last);
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  data_byte;
  logic        end_of_stream;
  logic        out_valid;
  logic        out_ready;
  logic        result_kind;
  logic [7:0]  payload_byte;
  logic [2:0]  status;
  logic [7:0]  version;
  logic [7:0]  message_type;
  logic [15:0] payload_length;
  logic [15:0] crc_received;
  logic [15:0] crc_calc;
  logic [15:0] bad_magic;
  logic [31:0] frame_offset;
  logic        last_result;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  stream_tracker sb;
  logic [7:0]    stream_bytes [$];
  logic [7:0]    cur_m1;
  logic [7:0]    cur_m2;
  int            send_idle;
  int            recv_idle;
  int            sent;
  int            cycles;
  res_t          seen;

  packet_deframer_crc16_check_core dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .data_byte_i      (data_byte),
    .end_of_stream_i  (end_of_stream),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .result_kind_o    (result_kind),
    .payload_byte_o   (payload_byte),
    .status_o         (status),
    .version_o        (version),
    .message_type_o   (message_type),
    .payload_length_o (payload_length),
    .crc_received_o   (crc_received),
    .crc_calc_o       (crc_calc),
    .bad_magic_o      (bad_magic),
    .frame_offset_o   (frame_offset),
    .last_result_o    (last_result),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= (recv_idle == 0) || ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      seen.kind   = kind_e'(result_kind);
      seen.pbyte  = payload_byte;
      seen.status = status_e'(status);
      seen.ver    = version;
      seen.mtype  = message_type;
      seen.len    = payload_length;
      seen.crcr   = crc_received;
      seen.crcc   = crc_calc;
      seen.bad    = bad_magic;
      seen.ofs    = frame_offset;
      sb.check_word(seen, last_result);
    end
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // header, crc and up to keep payload bytes; the crc is taken over the header fields and the kept bytes
  function automatic void add_frame(input logic [7:0] m1, m2, ver, typ,
                                    input logic [15:0] len, input bit crc_ok, input int keep);
    logic [7:0]  body [$];
    logic [15:0] c;
    int          n;
    body.push_back(ver);
    body.push_back(typ);
    body.push_back(len[15:8]);
    body.push_back(len[7:0]);
    n = (int'(len) < keep) ? int'(len) : keep;
    repeat (n) body.push_back(8'($urandom));
    c = 16'hFFFF;
    foreach (body[i]) c = stream_tracker::crc_next(c, body[i]);
    if (!crc_ok) c = c ^ 16'($urandom_range(1, 65535));
    stream_bytes.push_back(m1);
    stream_bytes.push_back(m2);
    foreach (body[i]) begin
      stream_bytes.push_back(body[i]);
      if (i == 3) begin
        stream_bytes.push_back(c[15:8]);
        stream_bytes.push_back(c[7:0]);
      end
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic eos);
    while (send_idle != 0 && $urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    data_byte     <= b;
    end_of_stream <= eos;
    do @(posedge clk); while (!in_ready);
    sb.note_byte(b, eos);
    sent++;
  endtask

  task automatic send_burst(input bit eos_last);
    logic [7:0] b;
    while (stream_bytes.size() != 0) begin
      b = stream_bytes.pop_front();
      send_byte(b, eos_last && stream_bytes.size() == 0);
    end
  endtask

  // let every expected word drain, then cover a byte still in flight with no word
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending_count() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic reg_write(input logic idx, input logic [7:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'h0, v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.set_magic(idx, v);
    if (idx == REG_MAGIC_FIRST) cur_m1 = v;
    else cur_m2 = v;
    @(posedge clk);
  endtask

  task automatic random_chunk();
    int          pick;
    logic [15:0] n;
    pick = $urandom_range(99);
    n = ($urandom_range(9) < 8) ? 16'($urandom_range(12)) : 16'($urandom_range(13, 48));
    if (pick < 70) begin
      add_frame(cur_m1, cur_m2, 8'($urandom), 8'($urandom), n, $urandom_range(9) != 0, 65536);
    end else if (pick < 80) begin
      // broken sync pair: first, second or both bytes wrong
      case ($urandom_range(2))
        0: add_frame(cur_m1 ^ 8'($urandom_range(1, 255)), cur_m2, 8'($urandom),
                     8'($urandom), 16'($urandom_range(4)), 1'b1, 65536);
        1: add_frame(cur_m1, cur_m2 ^ 8'($urandom_range(1, 255)), 8'($urandom),
                     8'($urandom), 16'($urandom_range(4)), 1'b1, 65536);
        default: add_frame(cur_m1 ^ 8'($urandom_range(1, 255)),
                           cur_m2 ^ 8'($urandom_range(1, 255)), 8'($urandom),
                           8'($urandom), 16'($urandom_range(4)), 1'b1, 65536);
      endcase
    end else if (pick < 90) begin
      repeat ($urandom_range(1, 12)) stream_bytes.push_back(8'($urandom));
    end else begin
      // junk ahead of a good frame makes the magic search realign inside the window
      repeat ($urandom_range(1, 3)) stream_bytes.push_back(8'($urandom));
      add_frame(cur_m1, cur_m2, 8'($urandom), 8'($urandom), n, 1'b1, 65536);
    end
    send_burst(1'b0);
  endtask

  task automatic close_stream();
    int         pick;
    logic [7:0] v;
    pick = $urandom_range(4);
    add_frame(cur_m1, cur_m2, 8'($urandom), 8'($urandom), 16'($urandom_range(5)), 1'b1, 65536);
    send_burst(1'b0);
    case (pick)
      0: begin
        // header cut short
        stream_bytes.push_back(cur_m1);
        stream_bytes.push_back(cur_m2);
        repeat ($urandom_range(5)) stream_bytes.push_back(8'($urandom));
      end
      1: add_frame(cur_m1, cur_m2, 8'($urandom), 8'($urandom),
                   16'($urandom_range(21, 65535)), 1'b1, $urandom_range(20));
      2: add_frame(cur_m1, cur_m2, 8'($urandom), 8'($urandom),
                   16'($urandom_range(1, 10)), $urandom_range(1) == 1, 65536);
      3: begin
        // bad sync on the last byte, with a sync pair left in the window
        stream_bytes.push_back(cur_m1 ^ 8'h01);
        repeat (2) stream_bytes.push_back(8'($urandom));
        stream_bytes.push_back(cur_m1);
        stream_bytes.push_back(cur_m2);
        repeat (3) stream_bytes.push_back(8'($urandom));
      end
      default: begin
        // still hunting when the stream ends
        repeat (9) begin
          do v = 8'($urandom); while (v == cur_m1);
          stream_bytes.push_back(v);
        end
      end
    endcase
    send_burst(1'b1);
  endtask

  initial begin
    int seg;
    int target;
    clk           = 1'b0;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    data_byte     = 8'h00;
    end_of_stream = 1'b0;
    out_ready     = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = 3'd0;
    pwdata        = 32'd0;
    sent          = 0;
    send_idle     = 21;
    recv_idle     = 50;
    cur_m1        = MAGIC_FIRST_RST;
    cur_m2        = MAGIC_SECOND_RST;
    sb            = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty frame, then a frame found by the magic search with a bad crc, then a bad second sync byte
    add_frame(cur_m1, cur_m2, 8'h00, 8'hFF, 16'd0, 1'b1, 65536);
    send_burst(1'b0);
    stream_bytes.push_back(8'h00);
    add_frame(cur_m1, cur_m2, 8'hFF, 8'h00, 16'd1, 1'b0, 65536);
    send_burst(1'b0);
    add_frame(cur_m1, ~cur_m2, 8'h5A, 8'hA5, 16'd0, 1'b1, 65536);
    send_burst(1'b0);

    for (seg = 0; seg < 4; seg++) begin
      if (seg == 1) begin
        send_idle = 50;
        recv_idle = 21;
      end
      if (seg == 2) begin
        send_idle = 0;
        recv_idle = 0;
      end
      if (seg > 0) begin
        settle();
        case (seg)
          1: begin
            reg_write(REG_MAGIC_FIRST, 8'h00);
            reg_write(REG_MAGIC_SECOND, 8'hFF);
          end
          2: begin
            reg_write(REG_MAGIC_FIRST, 8'hFF);
            reg_write(REG_MAGIC_SECOND, 8'h00);
          end
          default: begin
            reg_write(REG_MAGIC_FIRST, 8'($urandom));
            reg_write(REG_MAGIC_SECOND, 8'($urandom));
          end
        endcase
      end
      target = sent + 255;
      while (sent < target) random_chunk();
    end
    close_stream();
    // bytes after the end of the stream give no word
    repeat (3) send_byte(8'($urandom), 1'($urandom));
    settle();
    if (sb.faults == 0 && sb.pending_count() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
